// ===== sv/srct_pkg.sv =====
package srct_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        TURN_COLLINEAR = 2'd0,
        TURN_POS       = 2'd1,
        TURN_NEG       = 2'd2
    } t_turn;

endpackage

// ===== sv/srct_seg_test.sv =====
module srct_seg_test #(
    parameter int PW = srct_pkg::COORD_BITS_DEF + 2
) (
    input  logic signed [PW-1:0] i_e0_x,
    input  logic signed [PW-1:0] i_e0_y,
    input  logic signed [PW-1:0] i_e1_x,
    input  logic signed [PW-1:0] i_e1_y,
    input  logic signed [PW-1:0] i_s0_x,
    input  logic signed [PW-1:0] i_s0_y,
    input  logic signed [PW-1:0] i_s1_x,
    input  logic signed [PW-1:0] i_s1_y,
    output logic                 o_meet
);

    localparam int DW = PW + 1;
    localparam int XW = 2 * PW + 3;

    // orientation of r seen from segment p-q, exact sign of the cross product
    function automatic srct_pkg::t_turn turn_of(
        input logic signed [PW-1:0] px,
        input logic signed [PW-1:0] py,
        input logic signed [PW-1:0] qx,
        input logic signed [PW-1:0] qy,
        input logic signed [PW-1:0] rx,
        input logic signed [PW-1:0] ry
    );
        logic signed [DW-1:0] dy1;
        logic signed [DW-1:0] dx2;
        logic signed [DW-1:0] dx1;
        logic signed [DW-1:0] dy2;
        logic signed [XW-1:0] cr;
        dy1 = DW'(qy) - DW'(py);
        dx2 = DW'(rx) - DW'(qx);
        dx1 = DW'(qx) - DW'(px);
        dy2 = DW'(ry) - DW'(qy);
        cr  = XW'(dy1) * XW'(dx2) - XW'(dx1) * XW'(dy2);
        if (cr == '0) begin
            return srct_pkg::TURN_COLLINEAR;
        end else if (cr[XW-1]) begin
            return srct_pkg::TURN_NEG;
        end else begin
            return srct_pkg::TURN_POS;
        end
    endfunction

    // q lies in the bounding box of p and r
    function automatic logic on_box(
        input logic signed [PW-1:0] px,
        input logic signed [PW-1:0] py,
        input logic signed [PW-1:0] qx,
        input logic signed [PW-1:0] qy,
        input logic signed [PW-1:0] rx,
        input logic signed [PW-1:0] ry
    );
        logic signed [PW-1:0] xlo;
        logic signed [PW-1:0] xhi;
        logic signed [PW-1:0] ylo;
        logic signed [PW-1:0] yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    srct_pkg::t_turn o1, o2, o3, o4;

    always_comb begin
        o1 = turn_of(i_e0_x, i_e0_y, i_e1_x, i_e1_y, i_s0_x, i_s0_y);
        o2 = turn_of(i_e0_x, i_e0_y, i_e1_x, i_e1_y, i_s1_x, i_s1_y);
        o3 = turn_of(i_s0_x, i_s0_y, i_s1_x, i_s1_y, i_e0_x, i_e0_y);
        o4 = turn_of(i_s0_x, i_s0_y, i_s1_x, i_s1_y, i_e1_x, i_e1_y);
        o_meet = ((o1 != o2) && (o3 != o4))
            || ((o1 == srct_pkg::TURN_COLLINEAR)
                && on_box(i_e0_x, i_e0_y, i_s0_x, i_s0_y, i_e1_x, i_e1_y))
            || ((o2 == srct_pkg::TURN_COLLINEAR)
                && on_box(i_e0_x, i_e0_y, i_s1_x, i_s1_y, i_e1_x, i_e1_y))
            || ((o3 == srct_pkg::TURN_COLLINEAR)
                && on_box(i_s0_x, i_s0_y, i_e0_x, i_e0_y, i_s1_x, i_s1_y))
            || ((o4 == srct_pkg::TURN_COLLINEAR)
                && on_box(i_s0_x, i_s0_y, i_e1_x, i_e1_y, i_s1_x, i_s1_y));
    end

endmodule

// ===== sv/swept_rect_collision_test_unit.sv =====
// Swept rectangle collision test. Each request carries the previous and current
// center/size rectangles of a moving box and a check rectangle; the unit forms
// the center-to-center and four corner-to-corner sweep segments and reports
// o_hit when any of them meets or touches an edge of the check rectangle (a
// segment lying wholly inside the check rectangle is not a hit). One request is
// taken per clock while o_stall is low. An accepted request is held in the input
// register, and the twenty parallel exact segment tests settle into the result
// register once it is empty or not stalled; o_valid follows the result register.
// A stalled result does not block the next request, which waits in the input
// register; only when both registers are full and the result is stalled is
// o_stall raised.
module swept_rect_collision_test_unit #(
    parameter int COORD_BITS = srct_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_prev_x,
    input  logic [COORD_BITS-1:0] i_prev_y,
    input  logic [COORD_BITS-1:0] i_prev_w,
    input  logic [COORD_BITS-1:0] i_prev_h,
    input  logic [COORD_BITS-1:0] i_curr_x,
    input  logic [COORD_BITS-1:0] i_curr_y,
    input  logic [COORD_BITS-1:0] i_curr_w,
    input  logic [COORD_BITS-1:0] i_curr_h,
    input  logic [COORD_BITS-1:0] i_chk_x,
    input  logic [COORD_BITS-1:0] i_chk_y,
    input  logic [COORD_BITS-1:0] i_chk_w,
    input  logic [COORD_BITS-1:0] i_chk_h,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_hit
);

    localparam int CB = COORD_BITS;
    localparam int PW = CB + 2;

    logic          r_s1_vld, n_s1_vld;
    logic          r_s2_vld, n_s2_vld;
    logic          r_hit;
    logic [CB-1:0] r_prev_x, r_prev_y, r_prev_w, r_prev_h;
    logic [CB-1:0] r_curr_x, r_curr_y, r_curr_w, r_curr_h;
    logic [CB-1:0] r_chk_x, r_chk_y, r_chk_w, r_chk_h;

    logic in_acc;
    logic s2_take;
    logic hit;

    assign s2_take  = !r_s2_vld || !i_stall;
    assign o_stall  = r_s1_vld && !s2_take;
    assign in_acc   = i_valid && !o_stall;
    assign n_s1_vld = in_acc || o_stall;
    assign n_s2_vld = s2_take ? r_s1_vld : r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_prev_x <= i_prev_x;
            r_prev_y <= i_prev_y;
            r_prev_w <= i_prev_w;
            r_prev_h <= i_prev_h;
            r_curr_x <= i_curr_x;
            r_curr_y <= i_curr_y;
            r_curr_w <= i_curr_w;
            r_curr_h <= i_curr_h;
            r_chk_x  <= i_chk_x;
            r_chk_y  <= i_chk_y;
            r_chk_w  <= i_chk_w;
            r_chk_h  <= i_chk_h;
        end
        if (s2_take) begin
            r_hit <= hit;
        end
    end

    // doubled-scale centers and sizes
    logic signed [PW-1:0] px2, py2, pw, ph;
    logic signed [PW-1:0] cx2, cy2, cw, ch;
    logic signed [PW-1:0] kx2, ky2, kw, kh;

    assign px2 = {r_prev_x[CB-1], r_prev_x, 1'b0};
    assign py2 = {r_prev_y[CB-1], r_prev_y, 1'b0};
    assign cx2 = {r_curr_x[CB-1], r_curr_x, 1'b0};
    assign cy2 = {r_curr_y[CB-1], r_curr_y, 1'b0};
    assign kx2 = {r_chk_x[CB-1], r_chk_x, 1'b0};
    assign ky2 = {r_chk_y[CB-1], r_chk_y, 1'b0};
    assign pw  = {2'b00, r_prev_w};
    assign ph  = {2'b00, r_prev_h};
    assign cw  = {2'b00, r_curr_w};
    assign ch  = {2'b00, r_curr_h};
    assign kw  = {2'b00, r_chk_w};
    assign kh  = {2'b00, r_chk_h};

    logic signed [PW-1:0] sa_x[5], sa_y[5], sb_x[5], sb_y[5];
    logic signed [PW-1:0] ea_x[4], ea_y[4], eb_x[4], eb_y[4];

    // sweep segments: center, then corners
    assign sa_x[0] = px2;      assign sa_y[0] = py2;
    assign sb_x[0] = cx2;      assign sb_y[0] = cy2;
    assign sa_x[1] = px2 - pw; assign sa_y[1] = py2 - ph;
    assign sb_x[1] = cx2 - cw; assign sb_y[1] = cy2 - ch;
    assign sa_x[2] = px2 + pw; assign sa_y[2] = py2 - ph;
    assign sb_x[2] = cx2 + cw; assign sb_y[2] = cy2 - ch;
    assign sa_x[3] = px2 - pw; assign sa_y[3] = py2 + ph;
    assign sb_x[3] = cx2 - cw; assign sb_y[3] = cy2 + ch;
    assign sa_x[4] = px2 + pw; assign sa_y[4] = py2 + ph;
    assign sb_x[4] = cx2 + cw; assign sb_y[4] = cy2 + ch;

    // check rectangle edges: bottom, left, right, top
    assign ea_x[0] = kx2 - kw; assign ea_y[0] = ky2 - kh;
    assign eb_x[0] = kx2 + kw; assign eb_y[0] = ky2 - kh;
    assign ea_x[1] = kx2 - kw; assign ea_y[1] = ky2 - kh;
    assign eb_x[1] = kx2 - kw; assign eb_y[1] = ky2 + kh;
    assign ea_x[2] = kx2 + kw; assign ea_y[2] = ky2 - kh;
    assign eb_x[2] = kx2 + kw; assign eb_y[2] = ky2 + kh;
    assign ea_x[3] = kx2 - kw; assign ea_y[3] = ky2 + kh;
    assign eb_x[3] = kx2 + kw; assign eb_y[3] = ky2 + kh;

    logic [19:0] meet;

    for (genvar gi = 0; gi < 5; gi++) begin : g_seg
        for (genvar gj = 0; gj < 4; gj++) begin : g_edge
            srct_seg_test #(
                .PW(PW)
            ) u_test (
                .i_e0_x(ea_x[gj]),
                .i_e0_y(ea_y[gj]),
                .i_e1_x(eb_x[gj]),
                .i_e1_y(eb_y[gj]),
                .i_s0_x(sa_x[gi]),
                .i_s0_y(sa_y[gi]),
                .i_s1_x(sb_x[gi]),
                .i_s1_y(sb_y[gi]),
                .o_meet(meet[gi*4+gj])
            );
        end
    end

    assign hit     = |meet;
    assign o_valid = r_s2_vld;
    assign o_hit   = r_hit;

endmodule

// ===== sv/srct_checker.sv =====
module srct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit)))
        else $error("stalled result changed");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input side only stalls when the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back pressure");

    // accepted request is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("accepted request produced no result");

endmodule

bind swept_rect_collision_test_unit srct_checker u_srct_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_hit  (o_hit)
);
